@@ design/wsfd_pkg.sv @@
// shared constants and types for the websocket frame deframer
`default_nettype none

package wsfd_pkg;

   localparam int LENGTH_BITS = 64;
   localparam int PAT_LEN     = 16;

   localparam logic [3:0] OPC_TEXT  = 4'h1;
   localparam logic [3:0] OPC_CLOSE = 4'h8;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // first character sits in the top byte
   localparam logic [8*PAT_LEN-1:0] SNAP_PAT = {"request", "_", "snapshot"};

   function automatic logic [7:0] pat_byte(input int idx);
      pat_byte = SNAP_PAT[8*(PAT_LEN-1-idx) +: 8];
   endfunction

   // what one accepted word does, as seen by the matcher and the output stage
   typedef struct packed {
      logic       emit;
      logic       payload;
      logic       last;
      logic       clear;
      logic [7:0] data;
      logic [3:0] opcode;
   } step_type;

endpackage

`default_nettype wire

@@ design/wsfd_parse.sv @@
// header parser, length counter and payload unmasking
`default_nettype none

module wsfd_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   output wsfd_pkg::step_type     step
);

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_MASK    = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CLOSED  = 3'd6
   } phase_type;

   localparam int LB = wsfd_pkg::LENGTH_BITS;

   phase_type         phase_ff, phase_in;
   logic [3:0]        opcode_ff, opcode_in;
   logic              mask_en_ff, mask_en_in;
   logic [LB-1:0]     length_ff, length_in;
   logic [2:0]        ext_idx_ff, ext_idx_in;
   logic [31:0]       key_ff, key_in;
   logic [1:0]        mask_phase_ff, mask_phase_in;

   logic [LB-1:0]     length_shift;
   logic [LB-1:0]     length_dec;
   logic [LB-1:0]     length_hdr;
   logic [31:0]       key_rot;
   logic [7:0]        unmasked;
   logic              ext_last;

   // big-endian accumulate with saturation on overflow
   assign length_shift = (length_ff[LB-1 -: 8] != 8'd0) ? {LB{1'b1}}
                                                        : {length_ff[LB-9:0], rx_byte};
   assign length_dec   = length_ff - {{(LB-1){1'b0}}, 1'b1};
   assign key_rot      = key_ff << {mask_phase_ff, 3'b000};
   assign unmasked     = mask_en_ff ? (rx_byte ^ key_rot[31:24]) : rx_byte;
   assign ext_last     = (phase_ff == PH_EXT16) ? (ext_idx_ff >= 3'd1)
                                                : (ext_idx_ff >= 3'd7);

   always_comb begin
      phase_in      = phase_ff;
      opcode_in     = opcode_ff;
      mask_en_in    = mask_en_ff;
      length_in     = length_ff;
      ext_idx_in    = ext_idx_ff;
      key_in        = key_ff;
      mask_phase_in = mask_phase_ff;
      length_hdr    = length_ff;
      step          = '0;
      step.opcode   = opcode_ff;
      step.data     = 8'd0;

      unique case (phase_ff)
         PH_HDR1: begin
            mask_en_in = rx_byte[7];
            ext_idx_in = 3'd0;
            if (rx_byte[6:0] == wsfd_pkg::LEN_EXT16) begin
               length_in = '0;
               phase_in  = PH_EXT16;
            end else if (rx_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
               length_in = '0;
               phase_in  = PH_EXT64;
            end else begin
               length_hdr = {{(LB-7){1'b0}}, rx_byte[6:0]};
               length_in  = length_hdr;
               if (rx_byte[7]) begin
                  key_in   = '0;
                  phase_in = PH_MASK;
               end else begin
                  mask_phase_in = 2'd0;
                  if (length_hdr == '0) begin
                     step.emit = 1'b1;
                     step.last = 1'b1;
                     phase_in  = (opcode_ff == wsfd_pkg::OPC_CLOSE) ? PH_CLOSED : PH_HDR0;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_EXT16, PH_EXT64: begin
            length_in = length_shift;
            if (ext_last) begin
               ext_idx_in = 3'd0;
               if (mask_en_ff) begin
                  key_in   = '0;
                  phase_in = PH_MASK;
               end else begin
                  mask_phase_in = 2'd0;
                  if (length_shift == '0) begin
                     step.emit = 1'b1;
                     step.last = 1'b1;
                     phase_in  = (opcode_ff == wsfd_pkg::OPC_CLOSE) ? PH_CLOSED : PH_HDR0;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end else begin
               ext_idx_in = ext_idx_ff + 3'd1;
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], rx_byte};
            if (ext_idx_ff >= 3'd3) begin
               mask_phase_in = 2'd0;
               if (length_ff == '0) begin
                  step.emit = 1'b1;
                  step.last = 1'b1;
                  phase_in  = (opcode_ff == wsfd_pkg::OPC_CLOSE) ? PH_CLOSED : PH_HDR0;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               ext_idx_in = ext_idx_ff + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            step.emit     = 1'b1;
            step.payload  = 1'b1;
            step.data     = unmasked;
            mask_phase_in = mask_phase_ff + 2'd1;
            length_in     = length_dec;
            if (length_dec == '0) begin
               step.last = 1'b1;
               phase_in  = (opcode_ff == wsfd_pkg::OPC_CLOSE) ? PH_CLOSED : PH_HDR0;
            end
         end
         PH_CLOSED: begin
            phase_in = PH_CLOSED;
         end
         default: begin
            // first header byte, also taken for the unused phase code
            opcode_in  = rx_byte[3:0];
            step.clear = 1'b1;
            phase_in   = PH_HDR1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         opcode_ff     <= 4'd0;
         mask_en_ff    <= 1'b0;
         length_ff     <= '0;
         ext_idx_ff    <= 3'd0;
         key_ff        <= 32'd0;
         mask_phase_ff <= 2'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         opcode_ff     <= opcode_in;
         mask_en_ff    <= mask_en_in;
         length_ff     <= length_in;
         ext_idx_ff    <= ext_idx_in;
         key_ff        <= key_in;
         mask_phase_ff <= mask_phase_in;
      end
   end

endmodule

`default_nettype wire

@@ design/wsfd_match.sv @@
// per-frame search for the snapshot request text in the payload
`default_nettype none

module wsfd_match (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire wsfd_pkg::step_type step,
   output logic                   found_now
);

   localparam int WIN = wsfd_pkg::PAT_LEN - 1;

   logic [7:0] recent_ff [WIN];
   logic [7:0] recent_in [WIN];
   logic       zero_ff, zero_in;
   logic       found_ff, found_in;
   logic       track;
   logic       hit;

   assign track = step.payload && !zero_ff && (step.data != 8'd0);

   always_comb begin
      hit = (step.data == wsfd_pkg::pat_byte(WIN));
      for (int i = 0; i < WIN; i++) begin
         if (recent_ff[i] != wsfd_pkg::pat_byte(i)) begin
            hit = 1'b0;
         end
      end
   end

   assign found_now = found_ff || (track && hit);

   always_comb begin
      recent_in = recent_ff;
      zero_in   = zero_ff;
      found_in  = found_ff;
      if (step.clear) begin
         for (int i = 0; i < WIN; i++) begin
            recent_in[i] = 8'd0;
         end
         zero_in  = 1'b0;
         found_in = 1'b0;
      end else if (step.payload && !zero_ff) begin
         if (step.data == 8'd0) begin
            // text ends at the first zero byte
            zero_in = 1'b1;
         end else begin
            found_in = found_now;
            for (int i = 0; i < WIN - 1; i++) begin
               recent_in[i] = recent_ff[i+1];
            end
            recent_in[WIN-1] = step.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN; i++) begin
            recent_ff[i] <= 8'd0;
         end
         zero_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else if (accept) begin
         recent_ff <= recent_in;
         zero_ff   <= zero_in;
         found_ff  <= found_in;
      end
   end

endmodule

`default_nettype wire

@@ design/websocket_frame_deframer_core.sv @@
// a result word is registered and shows in the cycle after its byte is accepted
// throughput: one byte per cycle unless rsp_ready stalls; output refills as it drains
// header bytes give no word, except the last header byte of an empty frame
// after a close frame ends every byte is taken and dropped until reset
// reset: synchronous, active high; parser back to the first header byte
`default_nettype none

module websocket_frame_deframer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_data_valid,
   output logic            rsp_frame_end,
   output logic [3:0]      rsp_frame_opcode,
   output logic            rsp_close_frame,
   output logic            rsp_snapshot_request
);

   wsfd_pkg::step_type step;
   logic               accept;
   logic               found_now;

   logic               valid_ff, valid_in;
   logic [7:0]         data_ff, data_in;
   logic               dvalid_ff, dvalid_in;
   logic               end_ff, end_in;
   logic [3:0]         opcode_ff, opcode_in;
   logic               close_ff, close_in;
   logic               snap_ff, snap_in;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   wsfd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .step    (step)
   );

   wsfd_match u_match (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .step      (step),
      .found_now (found_now)
   );

   always_comb begin
      valid_in  = valid_ff && !rsp_ready;
      data_in   = data_ff;
      dvalid_in = dvalid_ff;
      end_in    = end_ff;
      opcode_in = opcode_ff;
      close_in  = close_ff;
      snap_in   = snap_ff;
      if (accept) begin
         valid_in  = step.emit;
         data_in   = step.data;
         dvalid_in = step.payload;
         end_in    = step.last;
         opcode_in = step.opcode;
         close_in  = step.last && (step.opcode == wsfd_pkg::OPC_CLOSE);
         snap_in   = step.last && (step.opcode == wsfd_pkg::OPC_TEXT) && found_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff   <= data_in;
      dvalid_ff <= dvalid_in;
      end_ff    <= end_in;
      opcode_ff <= opcode_in;
      close_ff  <= close_in;
      snap_ff   <= snap_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_data_byte        = data_ff;
   assign rsp_data_valid       = dvalid_ff;
   assign rsp_frame_end        = end_ff;
   assign rsp_frame_opcode     = opcode_ff;
   assign rsp_close_frame      = close_ff;
   assign rsp_snapshot_request = snap_ff;

endmodule

`default_nettype wire
